// ----- design/qct_pkg.sv -----
// qct_pkg: types, character codes and helpers for the quoted command tokenizer
// used by qct_core, qct_burst, quoted_command_tokenizer and its checker

package qct_pkg;

   // character codes that steer quoting
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   // quoting modes (the fourth code is unused and acts as no quote)
   localparam logic [1:0] QM_NONE   = 2'd0;
   localparam logic [1:0] QM_DOUBLE = 2'd1;
   localparam logic [1:0] QM_SINGLE = 2'd2;

   // result kinds
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // most results one input item can cause
   localparam int MaxResults = 3;

   // one result item
   typedef struct packed {
      logic       kind;
      logic [7:0] char_out;
      logic       arg_last;
      logic       is_command;
      logic       unterminated;
      logic       last;
   } result_type;

   // all results of one input item, with their count
   typedef struct packed {
      result_type [MaxResults-1:0] res;
      logic [1:0]                  count;
   } bundle_type;

   // whitespace: tab through carriage return, space, next line, no-break space
   function automatic logic is_ws(input logic [7:0] c);
      return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
   endfunction

endpackage

// ----- design/quoted_command_tokenizer.sv -----
// quoted_command_tokenizer: top level of the shell-style argument tokenizer
// depends on qct_pkg, qct_core and qct_burst
//
//   channel   direction  ports
//   req_      in         req_valid req_ready req_char_in req_line_end
//   rsp_      out        rsp_valid rsp_ready rsp_kind rsp_char_out rsp_arg_last
//                        rsp_is_command rsp_unterminated rsp_last
//
// one character item is accepted per cycle while the burst register can load; its
// 0 to 3 results sit in the burst register and leave one per cycle while rsp_ready
// is high; the next item is taken in the cycle the last waiting result is taken
// req_ready drops while two or more results wait or a lone one is stalled
// synchronous reset empties the burst register and restores the tokenizer state

module quoted_command_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_char_out,
   output logic       rsp_arg_last,
   output logic       rsp_is_command,
   output logic       rsp_unterminated,
   output logic       rsp_last
);

   qct_pkg::bundle_type bundle;
   qct_pkg::result_type out_res;
   logic                can_load;
   logic                step;
   logic                pop;

   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = can_load;
   assign step      = req_valid && can_load;

   // tokenizer state and step logic
   qct_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .char_in  (req_char_in),
      .line_end (req_line_end),
      .bundle   (bundle)
   );

   // result register
   qct_burst u_burst (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .bundle    (bundle),
      .pop       (pop),
      .can_load  (can_load),
      .out_valid (rsp_valid),
      .out_res   (out_res)
   );

   assign rsp_kind         = out_res.kind;
   assign rsp_char_out     = out_res.char_out;
   assign rsp_arg_last     = out_res.arg_last;
   assign rsp_is_command   = out_res.is_command;
   assign rsp_unterminated = out_res.unterminated;
   assign rsp_last         = out_res.last;

endmodule

// ----- design/qct_core.sv -----
// qct_core: tokenizer state and the single-pass step for one character item
// depends on qct_pkg

module qct_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         char_in,
   input  logic               line_end,
   output qct_pkg::bundle_type bundle
);

   logic [1:0] quote_mode_ff, quote_mode_in;
   logic       prev_bs_ff, prev_bs_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] held_char_ff, held_char_in;
   logic       first_arg_ff, first_arg_in;

   // state update on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         quote_mode_ff <= qct_pkg::QM_NONE;
         prev_bs_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
         held_char_ff  <= 8'h00;
         first_arg_ff  <= 1'b1;
      end else if (step) begin
         quote_mode_ff <= quote_mode_in;
         prev_bs_ff    <= prev_bs_in;
         held_valid_ff <= held_valid_in;
         held_char_ff  <= held_char_in;
         first_arg_ff  <= first_arg_in;
      end
   end

   // step logic: classify the character, release held text, close the line
   always_comb begin
      logic       ws;
      logic       is_quote;
      logic       dq;
      logic       in_quote;
      logic       do_append;
      logic [1:0] n;
      qct_pkg::result_type [qct_pkg::MaxResults-1:0] res;

      ws            = qct_pkg::is_ws(char_in);
      is_quote      = (char_in == qct_pkg::CH_DQUOTE) || (char_in == qct_pkg::CH_SQUOTE);
      dq            = (char_in == qct_pkg::CH_DQUOTE);
      in_quote      = (quote_mode_ff == qct_pkg::QM_DOUBLE) ||
                      (quote_mode_ff == qct_pkg::QM_SINGLE);
      do_append     = 1'b0;
      n             = 2'd0;
      res           = '0;
      quote_mode_in = quote_mode_ff;
      held_valid_in = held_valid_ff;
      held_char_in  = held_char_ff;
      first_arg_in  = first_arg_ff;

      // character handling
      priority if (ws) begin
         if (in_quote) begin
            do_append = 1'b1;
         end else if (held_valid_ff) begin
            res[n] = '{qct_pkg::KIND_CHAR, held_char_ff, 1'b1, first_arg_ff, 1'b0, 1'b0};
            n             = n + 2'd1;
            held_valid_in = 1'b0;
            first_arg_in  = 1'b0;
         end
      end else if (is_quote && !prev_bs_ff) begin
         priority if (quote_mode_ff == qct_pkg::QM_DOUBLE) begin
            if (dq) quote_mode_in = qct_pkg::QM_NONE;
            else    do_append = 1'b1;
         end else if (quote_mode_ff == qct_pkg::QM_SINGLE) begin
            if (dq) do_append = 1'b1;
            else    quote_mode_in = qct_pkg::QM_NONE;
         end else begin
            quote_mode_in = dq ? qct_pkg::QM_DOUBLE : qct_pkg::QM_SINGLE;
         end
      end else if (is_quote && held_valid_ff) begin
         // escaped quote takes the place of the held backslash
         held_char_in = char_in;
      end else begin
         do_append = 1'b1;
      end

      // ordinary character: release the held one, hold this one
      if (do_append) begin
         if (held_valid_ff) begin
            res[n] = '{qct_pkg::KIND_CHAR, held_char_ff, 1'b0, first_arg_ff, 1'b0, 1'b0};
            n = n + 2'd1;
         end
         held_char_in  = char_in;
         held_valid_in = 1'b1;
      end

      prev_bs_in = (char_in == qct_pkg::CH_BSLASH);

      // end of line: flush, or report an open quote with text pending, then back to reset state
      if (line_end) begin
         if (held_valid_in && ((quote_mode_in == qct_pkg::QM_DOUBLE) ||
                               (quote_mode_in == qct_pkg::QM_SINGLE))) begin
            res[n] = '{qct_pkg::KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0};
            n = n + 2'd1;
         end else begin
            if (held_valid_in) begin
               res[n] = '{qct_pkg::KIND_CHAR, held_char_in, 1'b1, first_arg_in, 1'b0, 1'b0};
               n = n + 2'd1;
            end
            res[n] = '{qct_pkg::KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
            n = n + 2'd1;
         end
         quote_mode_in = qct_pkg::QM_NONE;
         prev_bs_in    = 1'b0;
         held_valid_in = 1'b0;
         held_char_in  = 8'h00;
         first_arg_in  = 1'b1;
      end

      // mark the final result of this item
      if (n != 2'd0) begin
         res[n - 2'd1].last = 1'b1;
      end

      bundle.res   = res;
      bundle.count = n;
   end

endmodule

// ----- design/qct_burst.sv -----
// qct_burst: result register holding up to three results of one item
// depends on qct_pkg; drains one result per accepted output handshake

module qct_burst (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  qct_pkg::bundle_type bundle,
   input  logic                pop,
   output logic                can_load,
   output logic                out_valid,
   output qct_pkg::result_type out_res
);

   qct_pkg::result_type [qct_pkg::MaxResults-1:0] slot_ff;
   logic [1:0] count_ff;

   // count of waiting results
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (load) begin
         count_ff <= bundle.count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   // result slots, shifted toward slot 0 as they go out
   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= bundle.res;
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   // a new item may load once the buffer is empty or emptying now
   assign can_load  = (count_ff == 2'd0) || (count_ff == 2'd1 && pop);
   assign out_valid = (count_ff != 2'd0);
   assign out_res   = slot_ff[0];

endmodule

// ----- design/qct_checker.sv -----
// qct_checker: port-level assertions for quoted_command_tokenizer
// depends on qct_pkg; bound to the top level below

module qct_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_line_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_char_out,
   input logic       rsp_arg_last,
   input logic       rsp_is_command,
   input logic       rsp_unterminated,
   input logic       rsp_last
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out) &&
                                  $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled result item changed");

   // a status item always closes the results of its item and carries no text
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == qct_pkg::KIND_STATUS |->
         rsp_last && rsp_char_out == 8'h00 && !rsp_arg_last && !rsp_is_command)
      else $error("malformed status item");

   // a character item never flags an open quote
   a_char_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == qct_pkg::KIND_CHAR |-> !rsp_unterminated)
      else $error("character item marked unterminated");

   // an accepted line end item leaves a result waiting in the next cycle
   a_line_end_status: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_line_end |=> rsp_valid)
      else $error("no result after a line end item");

   // nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind quoted_command_tokenizer qct_checker u_qct_checker (.*);

// ----- tb/tb_quoted_command_tokenizer.sv -----
// tb_quoted_command_tokenizer: self-checking testbench for the quoted command tokenizer
// depends on qct_pkg and quoted_command_tokenizer; sends character items, predicts the
// argument characters and line status items, and checks every result in order

module tb_quoted_command_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   // one character item waiting to be sent, or a pause until all results are back
   typedef struct {
      logic [7:0] ch;
      logic       eol;
      bit         drain;
   } char_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_in = 8'h00;
   logic       req_line_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_char_out;
   logic       rsp_arg_last;
   logic       rsp_is_command;
   logic       rsp_unterminated;
   logic       rsp_last;

   char_item_type       chars_to_send[$];
   qct_pkg::result_type expected_tokens[$];
   int                  fail_count = 0;

   // handshakes seen at the last rising edge
   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;

   // idle counters for both sides
   int send_gap = 0;
   int send_calm = 0;
   int recv_gap = 0;
   int recv_calm = 0;

   // tokenizer state as predicted
   logic [1:0] quoting = qct_pkg::QM_NONE;
   logic       after_bslash = 1'b0;
   logic       pend_valid = 1'b0;
   logic [7:0] pend_char = 8'h00;
   logic       in_command = 1'b1;

   quoted_command_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_char_out     (rsp_char_out),
      .rsp_arg_last     (rsp_arg_last),
      .rsp_is_command   (rsp_is_command),
      .rsp_unterminated (rsp_unterminated),
      .rsp_last         (rsp_last)
   );

   always #2 clock = ~clock;

   function automatic qct_pkg::result_type mk_result(input logic kind, input logic [7:0] ch,
                                                     input logic alast, input logic cmd,
                                                     input logic unt);
      qct_pkg::result_type r;
      r.kind = kind;
      r.char_out = ch;
      r.arg_last = alast;
      r.is_command = cmd;
      r.unterminated = unt;
      r.last = 1'b0;
      return r;
   endfunction

   // mostly no gap, some short ones, a few long ones, and calm stretches with none
   function automatic int pick_gap(inout int calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // release the held character (not last) and hold the new one
   task automatic hold_char(input logic [7:0] c);
      if (pend_valid) begin
         expected_tokens.push_back(mk_result(qct_pkg::KIND_CHAR, pend_char, 1'b0,
                                             in_command, 1'b0));
      end
      pend_char = c;
      pend_valid = 1'b1;
   endtask

   // predict the results of one accepted character item
   task automatic tokenize_char(input logic [7:0] c, input logic eol);
      int  first_new;
      bit  blank;
      bit  quoted;
      bit  is_quote;
      first_new = expected_tokens.size();
      case (c)
         8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h85, 8'hA0: blank = 1'b1;
         default: blank = 1'b0;
      endcase
      quoted = (quoting == qct_pkg::QM_DOUBLE) || (quoting == qct_pkg::QM_SINGLE);
      is_quote = (c == qct_pkg::CH_DQUOTE) || (c == qct_pkg::CH_SQUOTE);

      if (blank) begin
         // whitespace is text inside quotes, a separator outside
         if (quoted) begin
            hold_char(c);
         end else if (pend_valid) begin
            expected_tokens.push_back(mk_result(qct_pkg::KIND_CHAR, pend_char, 1'b1,
                                                in_command, 1'b0));
            pend_valid = 1'b0;
            in_command = 1'b0;
         end
      end else if (is_quote && !after_bslash) begin
         // quote switching; the other kind of quote is literal
         if (quoting == qct_pkg::QM_DOUBLE) begin
            if (c == qct_pkg::CH_DQUOTE) quoting = qct_pkg::QM_NONE;
            else hold_char(c);
         end else if (quoting == qct_pkg::QM_SINGLE) begin
            if (c == qct_pkg::CH_SQUOTE) quoting = qct_pkg::QM_NONE;
            else hold_char(c);
         end else begin
            quoting = (c == qct_pkg::CH_DQUOTE) ? qct_pkg::QM_DOUBLE : qct_pkg::QM_SINGLE;
         end
      end else if (is_quote && pend_valid) begin
         // escaped quote takes the place of the held backslash
         pend_char = c;
      end else begin
         hold_char(c);
      end
      after_bslash = (c == qct_pkg::CH_BSLASH);

      // line end: flush or flag, then back to the reset state
      if (eol) begin
         quoted = (quoting == qct_pkg::QM_DOUBLE) || (quoting == qct_pkg::QM_SINGLE);
         if (pend_valid && quoted) begin
            expected_tokens.push_back(mk_result(qct_pkg::KIND_STATUS, 8'h00, 1'b0, 1'b0,
                                                1'b1));
         end else begin
            if (pend_valid) begin
               expected_tokens.push_back(mk_result(qct_pkg::KIND_CHAR, pend_char, 1'b1,
                                                   in_command, 1'b0));
            end
            expected_tokens.push_back(mk_result(qct_pkg::KIND_STATUS, 8'h00, 1'b0, 1'b0,
                                                1'b0));
         end
         quoting = qct_pkg::QM_NONE;
         after_bslash = 1'b0;
         pend_valid = 1'b0;
         pend_char = 8'h00;
         in_command = 1'b1;
      end

      if (expected_tokens.size() > first_new) expected_tokens[$].last = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input qct_pkg::result_type got,
                                  input qct_pkg::result_type want);
      fail_count++;
      if (fail_count <= 40) begin
         $display({"mismatch, %s: got kind=%0b char=%02h alast=%0b cmd=%0b unt=%0b last=%0b,",
                   " want kind=%0b char=%02h alast=%0b cmd=%0b unt=%0b last=%0b"},
                  what, got.kind, got.char_out, got.arg_last, got.is_command,
                  got.unterminated, got.last, want.kind, want.char_out, want.arg_last,
                  want.is_command, want.unterminated, want.last);
      end
   endtask

   task automatic add_char(input logic [7:0] c, input logic eol);
      chars_to_send.push_back('{ch: c, eol: eol, drain: 1'b0});
   endtask

   // sample handshakes, predict accepted items and check accepted results
   always @(posedge clock) begin
      qct_pkg::result_type got;
      qct_pkg::result_type want;
      req_fire = !reset && req_valid && req_ready;
      rsp_fire = !reset && rsp_valid && rsp_ready;
      if (req_fire) tokenize_char(req_char_in, req_line_end);
      if (rsp_fire) begin
         got.kind = rsp_kind;
         got.char_out = rsp_char_out;
         got.arg_last = rsp_arg_last;
         got.is_command = rsp_is_command;
         got.unterminated = rsp_unterminated;
         got.last = rsp_last;
         if (expected_tokens.size() == 0) begin
            report_mismatch("result with nothing expected", got, '0);
         end else begin
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.char_out !== want.char_out ||
                got.arg_last !== want.arg_last || got.is_command !== want.is_command ||
                got.unterminated !== want.unterminated || got.last !== want.last) begin
               report_mismatch("wrong result", got, want);
            end
         end
      end
   end

   // sender: next item from the queue after a random gap
   always @(negedge clock) begin
      char_item_type nxt;
      bit            send;
      send = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (chars_to_send.size() > 0 && chars_to_send[0].drain) begin
            // hold off until every expected result is back
            if (expected_tokens.size() == 0) void'(chars_to_send.pop_front());
         end else if (chars_to_send.size() > 0) begin
            nxt = chars_to_send.pop_front();
            req_char_in <= nxt.ch;
            req_line_end <= nxt.eol;
            send = 1'b1;
            send_gap = pick_gap(send_calm);
         end
         req_valid <= send;
      end
   end

   // receiver: ready stays up until a result is taken, then a random stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_fire) recv_gap = pick_gap(recv_calm);
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      int         line_len;
      int         r;
      bit         noise;
      logic [7:0] c;

      // directed: byte extremes, 00 alone on a line, three results from one item
      add_char(8'h00, 1'b1);
      add_char(8'hFF, 1'b0);
      add_char(8'h09, 1'b0);
      add_char("a", 1'b0);
      add_char(8'h0D, 1'b1);
      add_char("b", 1'b0);
      add_char("c", 1'b1);
      // empty quoted argument, whitespace and double quote inside single quotes
      add_char(qct_pkg::CH_DQUOTE, 1'b0);
      add_char(qct_pkg::CH_DQUOTE, 1'b0);
      add_char(8'h20, 1'b0);
      add_char(qct_pkg::CH_SQUOTE, 1'b0);
      add_char(8'h85, 1'b0);
      add_char(qct_pkg::CH_DQUOTE, 1'b0);
      add_char(qct_pkg::CH_SQUOTE, 1'b0);
      add_char(8'h0A, 1'b1);
      // escaped double quote, then a quote left open with text pending
      add_char(qct_pkg::CH_BSLASH, 1'b0);
      add_char(qct_pkg::CH_DQUOTE, 1'b0);
      add_char(qct_pkg::CH_DQUOTE, 1'b1);
      // quote open with an empty argument at line end is fine
      add_char(qct_pkg::CH_SQUOTE, 1'b1);
      // single quote inside double quotes, open at line end
      add_char(qct_pkg::CH_DQUOTE, 1'b0);
      add_char(qct_pkg::CH_SQUOTE, 1'b0);
      add_char(8'h0B, 1'b0);
      add_char(8'hA0, 1'b0);
      add_char(8'h0C, 1'b1);
      // escaped single quote, line ends on whitespace
      add_char("a", 1'b0);
      add_char(qct_pkg::CH_BSLASH, 1'b0);
      add_char(qct_pkg::CH_SQUOTE, 1'b0);
      add_char(8'h20, 1'b1);
      chars_to_send.push_back('{ch: 8'h00, eol: 1'b0, drain: 1'b1});

      // random lines: mostly text with quotes, escapes and blanks, some pure noise
      while (chars_to_send.size() < 400) begin
         line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
         noise = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < line_len; i++) begin
            r = $urandom_range(0, 99);
            if (noise || r >= 86) c = 8'($urandom_range(0, 255));
            else if (r < 40) c = 8'($urandom_range(8'h61, 8'h7A));
            else if (r < 55) c = 8'h20;
            else if (r < 63) c = qct_pkg::CH_DQUOTE;
            else if (r < 70) c = qct_pkg::CH_SQUOTE;
            else if (r < 77) c = qct_pkg::CH_BSLASH;
            else begin
               case ($urandom_range(0, 6))
                  0: c = 8'h09;
                  1: c = 8'h0A;
                  2: c = 8'h0B;
                  3: c = 8'h0C;
                  4: c = 8'h0D;
                  5: c = 8'h85;
                  default: c = 8'hA0;
               endcase
            end
            add_char(c, i == line_len - 1);
         end
         if ($urandom_range(0, 19) == 0) begin
            chars_to_send.push_back('{ch: 8'h00, eol: 1'b0, drain: 1'b1});
         end
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      while (chars_to_send.size() > 0 || req_valid) @(posedge clock);
      while (expected_tokens.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
